// File: design/mbps_pkg.sv
// mbps_pkg: shared types and constants of the masked byte pattern scan unit
// no dependencies; used by the interfaces and by every module of the block

package mbps_pkg;

  // fixed field widths
  localparam int BYTE_W       = 8;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int LEN_W        = 6;
  localparam int HIT_W        = 31;
  localparam int OFFSET_OUT_W = 32;

  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic [HIT_W-1:0]        hit_t;
  typedef logic [OFFSET_OUT_W-1:0] offset_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_0   = 3'd0,
    REG_PATTERN_1   = 3'd1,
    REG_PATTERN_2   = 3'd2,
    REG_PATTERN_3   = 3'd3,
    REG_CARE_MASK   = 3'd4,
    REG_PATTERN_LEN = 3'd5,
    REG_MATCH_INDEX = 3'd6
  } cfg_reg_t;

  // scalar settings handed from the register file to the scan datapath
  typedef struct packed {
    logic   all_wild;
    len_t   len;
    hit_t   index;
  } cfg_ctl_t;

  // one result as produced by the scan datapath
  typedef struct packed {
    logic    valid;
    logic    found;
    offset_t offset;
  } scan_res_t;

endpackage

// File: design/mbps_if.sv
// mbps_if: valid/ready channel interfaces of the masked byte pattern scan unit
// depends on mbps_pkg for payload types

// image byte channel
interface mbps_in_if;
  logic                             valid;
  logic                             ready;
  logic [mbps_pkg::BYTE_W-1:0]      image_byte;
  logic                             last_byte;

  modport source (output valid, output image_byte, output last_byte, input ready);
  modport sink   (input valid, input image_byte, input last_byte, output ready);
endinterface

// result channel
interface mbps_out_if;
  logic                 valid;
  logic                 ready;
  logic                 found;
  mbps_pkg::offset_t    match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// register write channel
interface mbps_cfg_if;
  logic                 valid;
  logic                 ready;
  mbps_pkg::cfg_idx_t   index;
  mbps_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/masked_byte_pattern_scan_unit.sv
// masked_byte_pattern_scan_unit: top level of the masked byte pattern scan
// depends on mbps_pkg, mbps_if, mbps_cfg and mbps_scan

// Streams image bytes, one per transaction, and reports the start offset of the
// Nth place where a pattern of up to MAX_PATTERN bytes matches, with care-mask
// wildcards and overlapping matches counted. One transaction closes each image:
// found with the offset as soon as the Nth match completes (later bytes of that
// image give nothing), or not-found with offset 0 at the byte marked last. The
// block takes one byte every cycle; an accepted byte is held in the input
// register and its result goes into the result register once that is free,
// through one compare stage that checks all window bytes at once. It stalls
// only while the result register is held by the sink, and input ready is low in
// any cycle with a register write pending. The derived pattern alignment is
// registered from the configuration registers.
// There is no clearing pass after reset.

module masked_byte_pattern_scan_unit #(
  parameter int MAX_PATTERN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  mbps_in_if.sink       in_ch,
  mbps_out_if.source    out_ch,
  mbps_cfg_if.sink      cfg_ch
);

  logic [MAX_PATTERN*8-1:0]  align_pat;
  logic [MAX_PATTERN-1:0]    align_care;
  mbps_pkg::cfg_ctl_t        ctl;
  mbps_pkg::scan_res_t       res;

  logic                      out_free;
  logic                      res_valid_r;
  logic                      found_r;
  mbps_pkg::offset_t         offset_r;

  // register file
  mbps_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ch       (cfg_ch),
    .align_pat_r  (align_pat),
    .align_care_r (align_care),
    .ctl_r        (ctl)
  );

  // scan datapath
  mbps_scan #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_free   (out_free),
    .cfg_hold   (cfg_ch.valid),
    .align_pat  (align_pat),
    .align_care (align_care),
    .ctl        (ctl),
    .res        (res)
  );

  assign out_free = !res_valid_r || out_ch.ready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (out_free) begin
      res_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      found_r  <= res.found;
      offset_r <= res.offset;
    end
  end

  assign out_ch.valid        = res_valid_r;
  assign out_ch.found        = found_r;
  assign out_ch.match_offset = offset_r;

endmodule

// File: design/mbps_cfg.sv
// mbps_cfg: configuration registers and the pattern/care alignment derived from them
// depends on mbps_pkg and mbps_cfg_if

module mbps_cfg #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mbps_cfg_if.sink                      cfg_ch,
  output logic [MAX_PATTERN*8-1:0]      align_pat_r,
  output logic [MAX_PATTERN-1:0]        align_care_r,
  output mbps_pkg::cfg_ctl_t            ctl_r
);

  localparam int PatW = MAX_PATTERN * mbps_pkg::BYTE_W;
  localparam mbps_pkg::len_t MaxLen = mbps_pkg::LEN_W'(MAX_PATTERN);

  logic [PatW-1:0]         pat_r;
  logic [MAX_PATTERN-1:0]  care_r;
  mbps_pkg::len_t          plen_r;
  mbps_pkg::hit_t          index_r;

  mbps_pkg::len_t          eff_len;
  mbps_pkg::len_t          sh;
  logic [MAX_PATTERN-1:0]  in_use;
  logic [MAX_PATTERN-1:0]  care_used;
  logic [MAX_PATTERN-1:0]  rev_care;
  logic [PatW-1:0]         rev_pat;
  logic [PatW-1:0]         align_pat_nxt;
  logic [MAX_PATTERN-1:0]  align_care_nxt;
  mbps_pkg::cfg_ctl_t      ctl_nxt;

  assign cfg_ch.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      care_r  <= '0;
      plen_r  <= mbps_pkg::LEN_W'(1);
      index_r <= mbps_pkg::HIT_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mbps_pkg::REG_PATTERN_0, mbps_pkg::REG_PATTERN_1,
        mbps_pkg::REG_PATTERN_2, mbps_pkg::REG_PATTERN_3: begin
          for (int k = 0; k < MAX_PATTERN; k++) begin
            if (cfg_ch.index[1:0] == 2'(k >> 3)) begin
              pat_r[k*8 +: 8] <= cfg_ch.data[(k & 7)*8 +: 8];
            end
          end
        end
        mbps_pkg::REG_CARE_MASK: begin
          care_r <= cfg_ch.data[MAX_PATTERN-1:0];
        end
        mbps_pkg::REG_PATTERN_LEN: begin
          plen_r <= cfg_ch.data[mbps_pkg::LEN_W-1:0];
        end
        mbps_pkg::REG_MATCH_INDEX: begin
          index_r <= cfg_ch.data[mbps_pkg::HIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // clamp the length and right-align the reversed pattern so that
  // window position j faces pattern byte len-1-j
  always_comb begin
    if (plen_r == '0) begin
      eff_len = mbps_pkg::LEN_W'(1);
    end else if (plen_r > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = plen_r;
    end
    sh = MaxLen - eff_len;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      in_use[j] = mbps_pkg::LEN_W'(j) < eff_len;
    end
    care_used = care_r & in_use;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      rev_pat[j*8 +: 8] = pat_r[(MAX_PATTERN-1-j)*8 +: 8];
      rev_care[j]       = care_used[MAX_PATTERN-1-j];
    end
    align_pat_nxt    = rev_pat >> {sh, 3'b000};
    align_care_nxt   = rev_care >> sh;
    ctl_nxt.all_wild = ~|care_used;
    ctl_nxt.len      = eff_len;
    ctl_nxt.index    = index_r;
  end

  // derived settings, registered from the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_pat_r    <= '0;
      align_care_r   <= '0;
      ctl_r.all_wild <= 1'b1;
      ctl_r.len      <= mbps_pkg::LEN_W'(1);
      ctl_r.index    <= mbps_pkg::HIT_W'(1);
    end else begin
      align_pat_r  <= align_pat_nxt;
      align_care_r <= align_care_nxt;
      ctl_r        <= ctl_nxt;
    end
  end

endmodule

// File: design/mbps_scan.sv
// mbps_scan: input register, byte window, masked compare and match counting
// depends on mbps_pkg and mbps_in_if

module mbps_scan #(
  parameter int MAX_PATTERN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mbps_in_if.sink                       in_ch,
  input  logic                          out_free,
  input  logic                          cfg_hold,
  input  logic [MAX_PATTERN*8-1:0]      align_pat,
  input  logic [MAX_PATTERN-1:0]        align_care,
  input  mbps_pkg::cfg_ctl_t            ctl,
  output mbps_pkg::scan_res_t           res
);

  localparam int OutW = mbps_pkg::OFFSET_OUT_W;

  // input register
  logic                           a_valid_r;
  logic [mbps_pkg::BYTE_W-1:0]    a_byte_r;
  logic                           a_last_r;

  // per-image state
  logic [mbps_pkg::BYTE_W-1:0]    win_r   [MAX_PATTERN];
  logic [mbps_pkg::BYTE_W-1:0]    win_nxt [MAX_PATTERN];
  logic [OFFSET_BITS-1:0]         pos_r;
  mbps_pkg::hit_t                 hit_r;
  logic                           reported_r;

  logic                           a_fire;
  logic [OFFSET_BITS-1:0]         taken;
  logic [OFFSET_BITS-1:0]         len_ext;
  logic [OFFSET_BITS-1:0]         start;
  logic                           pos_max;
  logic                           enough;
  logic [MAX_PATTERN-1:0]         ok;
  logic                           window_hit;
  logic                           is_match;
  mbps_pkg::hit_t                 hit_inc;
  logic                           found;

  assign a_fire      = a_valid_r && out_free;
  assign in_ch.ready = (!a_valid_r || out_free) && !cfg_hold;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      a_valid_r <= 1'b1;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_byte_r <= in_ch.image_byte;
      a_last_r <= in_ch.last_byte;
    end
  end

  // window with the new byte in front, compared against the aligned pattern
  always_comb begin
    win_nxt[0] = a_byte_r;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
    for (int j = 0; j < MAX_PATTERN; j++) begin
      ok[j] = !align_care[j] || (win_nxt[j] == align_pat[j*8 +: 8]);
    end
  end

  // position, match decision and nth-match check
  always_comb begin
    pos_max    = &pos_r;
    taken      = pos_r + 1'b1;
    len_ext    = OFFSET_BITS'(ctl.len);
    start      = taken - len_ext;
    enough     = !pos_max && (taken >= len_ext);
    window_hit = ctl.all_wild ? (taken == len_ext) : &ok;
    is_match   = !reported_r && enough && window_hit;
    hit_inc    = (&hit_r) ? hit_r : hit_r + 1'b1;
    found      = is_match && (ctl.index != '0) && (hit_inc == ctl.index);
    res.valid  = a_fire && (found || (a_last_r && !reported_r));
    res.found  = found;
    res.offset = found ? OutW'(start) : '0;
  end

  // window shift; stale bytes from an earlier image never reach a compare
  always_ff @(posedge clk) begin
    if (a_fire && !reported_r) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

  // per-image counters, cleared by the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      hit_r      <= '0;
      reported_r <= 1'b0;
    end else if (a_fire) begin
      if (a_last_r) begin
        pos_r      <= '0;
        hit_r      <= '0;
        reported_r <= 1'b0;
      end else if (!reported_r) begin
        if (!pos_max) begin
          pos_r <= taken;
        end
        if (is_match) begin
          hit_r <= hit_inc;
        end
        if (found) begin
          reported_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/mbps_checker.sv
// mbps_checker: port-level assertions for masked_byte_pattern_scan_unit
// depends on mbps_pkg; bound to the top level at the end of this file

module mbps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_found,
  input mbps_pkg::offset_t  out_match_offset,
  input logic               cfg_valid
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_match_offset))
    else $error("result changed while stalled");

  // not-found results carry a zero offset
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == '0)
    else $error("not-found result with nonzero offset");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // no byte is taken together with a register write
  a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> !in_ready)
    else $error("input ready during register write");

endmodule

bind masked_byte_pattern_scan_unit mbps_checker u_mbps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_found        (out_ch.found),
  .out_match_offset (out_ch.match_offset),
  .cfg_valid        (cfg_ch.valid)
);
